/* rtl/core/q24_pkg.sv */
// ----------------------------------------------------------------------------
// q24_pkg: shared types and constants
// Opcodes, defaults and the result flag type of the fixed-point ALU.
// ----------------------------------------------------------------------------
package q24_pkg;

   localparam int FRAC_BITS_DEF = 8;
   localparam int WORD_BITS_DEF = 32;
   localparam int DATA_BITS     = 32;   // operand and result field width
   localparam int FUNC_BITS     = 4;

   localparam logic [FUNC_BITS-1:0] OP_ADD  = 4'd0;
   localparam logic [FUNC_BITS-1:0] OP_SUB  = 4'd1;
   localparam logic [FUNC_BITS-1:0] OP_MUL  = 4'd2;
   localparam logic [FUNC_BITS-1:0] OP_DIV  = 4'd3;
   localparam logic [FUNC_BITS-1:0] OP_MIN  = 4'd4;
   localparam logic [FUNC_BITS-1:0] OP_MAX  = 4'd5;
   localparam logic [FUNC_BITS-1:0] OP_INC  = 4'd6;
   localparam logic [FUNC_BITS-1:0] OP_DEC  = 4'd7;
   localparam logic [FUNC_BITS-1:0] OP_I2F  = 4'd8;
   localparam logic [FUNC_BITS-1:0] OP_F2I  = 4'd9;

   // flags reported with each result
   typedef struct packed {
      logic a_less;
      logic a_equal;
      logic a_greater;
      logic overflowed;
      logic divided_by_zero;
   } flags_type;

endpackage

/* rtl/core/q24_div_cell.sv */
// ----------------------------------------------------------------------------
// q24_div_cell: one restoring-division step
// Shifts one numerator bit into the partial remainder and sets one quotient
// bit. Other payload rides through untouched.
// ----------------------------------------------------------------------------
module q24_div_cell
   import q24_pkg::*;
#(
   parameter int NB = 42,    // numerator / quotient width
   parameter int DB = 33,    // divisor width
   parameter int PB = 32     // pass-through payload width
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [NB-1:0] num_i,   // numerator, consumed MSB first
   input  logic [NB-1:0] quo_i,
   input  logic [DB:0]   rem_i,
   input  logic [DB-1:0] den_i,
   input  logic [PB-1:0] pay_i,
   output logic [NB-1:0] num_o,
   output logic [NB-1:0] quo_o,
   output logic [DB:0]   rem_o,
   output logic [DB-1:0] den_o,
   output logic [PB-1:0] pay_o
);

   logic [DB:0]   shifted;
   logic [DB+1:0] diff;
   logic [NB-1:0] num_ff, quo_ff;
   logic [DB:0]   rem_ff;
   logic [DB-1:0] den_ff;
   logic [PB-1:0] pay_ff;

   always_comb begin
      shifted = {rem_i[DB-1:0], num_i[NB-1]};
      diff    = {1'b0, shifted} - {2'b00, den_i};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff <= {num_i[NB-2:0], 1'b0};
         if (!diff[DB+1]) begin
            rem_ff <= diff[DB:0];
            quo_ff <= {quo_i[NB-2:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            quo_ff <= {quo_i[NB-2:0], 1'b0};
         end
         den_ff <= den_i;
         pay_ff <= pay_i;
      end
   end

   assign num_o = num_ff;
   assign quo_o = quo_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign pay_o = pay_ff;

endmodule

/* rtl/core/q24_alu.sv */
// ----------------------------------------------------------------------------
// q24_alu: front and back stages of the ALU
// Front: decode, simple ops, multiply, division set-up. Back: rounding of
// the product, saturation, result selection.
// ----------------------------------------------------------------------------
module q24_alu
   import q24_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF,
   parameter int NB = DATA_BITS + FRAC_BITS + 2,
   parameter int DB = DATA_BITS + 1
) (
   input  logic                        clock,
   input  logic                        enable,
   // front
   input  logic [FUNC_BITS-1:0]        func_i,
   input  logic signed [DATA_BITS-1:0] a_i,
   input  logic signed [DATA_BITS-1:0] b_i,
   output logic [NB-1:0]               num_o,
   output logic [DB-1:0]               den_o,
   output logic [DATA_BITS+FUNC_BITS+5:0] pay_o,
   output logic [2*DATA_BITS-1:0]      prod_o,
   // back
   input  logic [NB-1:0]               quo_i,
   input  logic [DATA_BITS+FUNC_BITS+5:0] pay_i,
   input  logic [2*DATA_BITS-1:0]      prod_i,
   output logic signed [DATA_BITS-1:0] result_o,
   output flags_type                   flags_o
);

   localparam int SAT_BITS = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;
   localparam int XB = 2 * DATA_BITS + 2;   // wide signed working width
   localparam logic signed [XB-1:0] SAT_HI = (XB'(1) <<< (SAT_BITS - 1)) - XB'(1);
   localparam logic signed [XB-1:0] SAT_LO = -SAT_HI - XB'(1);

   // payload: {neg, dz, flags(3), func, simple result, simple ovf}
   logic [DATA_BITS-1:0] mag_a, mag_b;
   logic signed [XB-1:0] wa, wb, simple;
   logic                 neg;
   logic [2:0]           cmp;
   logic                 dz;

   always_comb begin
      wa    = XB'(a_i);
      wb    = XB'(b_i);
      mag_a = a_i[DATA_BITS-1] ? DATA_BITS'(-a_i) : a_i;
      mag_b = b_i[DATA_BITS-1] ? DATA_BITS'(-b_i) : b_i;
      neg   = a_i[DATA_BITS-1] ^ b_i[DATA_BITS-1];
      cmp   = {a_i < b_i, a_i == b_i, a_i > b_i};
      dz    = (func_i == OP_DIV) && (b_i == '0);
      case (func_i)
         OP_ADD:  simple = wa + wb;
         OP_SUB:  simple = wa - wb;
         OP_MIN:  simple = (a_i < b_i) ? wa : wb;
         OP_MAX:  simple = (a_i < b_i) ? wb : wa;
         OP_INC:  simple = wa + XB'(1);
         OP_DEC:  simple = wa - XB'(1);
         OP_I2F:  simple = wa <<< FRAC_BITS;
         OP_F2I:  simple = wa >>> FRAC_BITS;
         OP_DIV:  simple = (a_i > 0) ? SAT_HI : ((a_i < 0) ? SAT_LO : '0);
         default: simple = '0;
      endcase
   end

   logic [2*DATA_BITS-1:0] prod_ff;
   always_ff @(posedge clock) begin
      if (enable) prod_ff <= mag_a * mag_b;
   end
   assign prod_o = prod_ff;

   // numerator 2*|a|<<F + |b| ; divisor is 2*|b| applied as quotient of
   // (2n+d)/(2d): we feed num = 2n+d and den = 2d
   always_comb begin
      num_o = (NB'(mag_a) << (FRAC_BITS + 1)) + NB'(mag_b);
      den_o = {mag_b, 1'b0};
   end
   // simple results clamp to saturation range here already
   logic signed [XB-1:0]  simple_c;
   logic                  simple_ov;
   always_comb begin
      simple_ov = 1'b0;
      simple_c  = simple;
      if (simple > SAT_HI) begin simple_c = SAT_HI; simple_ov = !dz; end
      if (simple < SAT_LO) begin simple_c = SAT_LO; simple_ov = !dz; end
   end
   assign pay_o = {neg, dz, cmp, func_i, simple_c[DATA_BITS-1:0], simple_ov};

   // back stage
   logic                 p_neg, p_dz, p_ov;
   logic [2:0]           p_cmp;
   logic [FUNC_BITS-1:0] p_func;
   logic [DATA_BITS-1:0] p_simple;
   logic [XB-1:0]        m_mag;
   logic signed [XB-1:0] sgn;
   logic signed [XB-1:0] clamped;
   logic                 ov;

   always_comb begin
      {p_neg, p_dz, p_cmp, p_func, p_simple, p_ov} = pay_i;
      if (p_func == OP_MUL)
         m_mag = XB'((prod_i + (2*DATA_BITS)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      else
         m_mag = XB'(quo_i);
      sgn = p_neg ? -$signed(m_mag) : $signed(m_mag);
      clamped = sgn;
      ov = 1'b0;
      if (sgn > SAT_HI) begin clamped = SAT_HI; ov = 1'b1; end
      if (sgn < SAT_LO) begin clamped = SAT_LO; ov = 1'b1; end
      flags_o.a_less          = p_cmp[2];
      flags_o.a_equal         = p_cmp[1];
      flags_o.a_greater       = p_cmp[0];
      flags_o.divided_by_zero = p_dz;
      if ((p_func == OP_MUL) || (p_func == OP_DIV && !p_dz)) begin
         result_o           = clamped[DATA_BITS-1:0];
         flags_o.overflowed = ov;
      end else begin
         result_o           = p_simple;
         flags_o.overflowed = p_ov;
      end
   end

endmodule

/* rtl/core/q24_8_fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu: pipelined signed fixed-point ALU
// Add, sub, mul, div, min, max, inc, dec, int/fixed conversion with compare,
// saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while rsp is not stalled; each
// result passes one front stage, a chain of NB restoring-division cells
// (NB = 32 + FRAC_BITS + 2, 42 at defaults), and an output register on
// its way from req to rsp. All operations share the same latency so
// results leave in order. The product is formed in the front stage and
// carried down the chain beside the divider. A stall on rsp freezes the
// whole pipeline; req_stall is high whenever the output holds a result
// that is being stalled, whether or not the chain behind it is full.
module q24_8_fixed_point_alu
   import q24_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [FUNC_BITS-1:0]        req_func,
   input  logic signed [DATA_BITS-1:0] req_operand_a,
   input  logic signed [DATA_BITS-1:0] req_operand_b,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DATA_BITS-1:0] rsp_result,
   output logic                        rsp_a_less,
   output logic                        rsp_a_equal,
   output logic                        rsp_a_greater,
   output logic                        rsp_overflowed,
   output logic                        rsp_divided_by_zero
);

   localparam int NB = DATA_BITS + FRAC_BITS + 2;
   localparam int DB = DATA_BITS + 1;
   localparam int PW = DATA_BITS + FUNC_BITS + 6;
   localparam int CW = PW + 2 * DATA_BITS;   // payload plus product

   logic advance;
   logic [NB:0] vld_ff;   // valid per cell; [0] is front register

   logic [NB-1:0] num0;
   logic [DB-1:0] den0;
   logic [PW-1:0] pay0;
   logic [2*DATA_BITS-1:0] prod1;

   logic [NB-1:0] num   [NB+1];
   logic [NB-1:0] quo   [NB+1];
   logic [DB:0]   rem   [NB+1];
   logic [DB-1:0] den   [NB+1];
   logic [CW-1:0] pay   [NB+1];

   logic signed [DATA_BITS-1:0] res_c;
   flags_type                   flg_c;

   // pipeline moves when the output slot is free or being emptied
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   q24_alu #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS), .NB(NB), .DB(DB)) u_alu (
      .clock(clock), .enable(advance),
      .func_i(req_func), .a_i(req_operand_a), .b_i(req_operand_b),
      .num_o(num0), .den_o(den0), .pay_o(pay0), .prod_o(prod1),
      .quo_i(quo[NB]), .pay_i(pay[NB][CW-1:2*DATA_BITS]),
      .prod_i(pay[NB][2*DATA_BITS-1:0]),
      .result_o(res_c), .flags_o(flg_c)
   );

   // front register for division set-up (product registered inside the alu)
   logic [NB-1:0] num_ff;
   logic [DB-1:0] den_ff;
   logic [PW-1:0] pay_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num0;
         den_ff <= den0;
         pay_ff <= pay0;
      end
   end

   assign num[0] = num_ff;
   assign quo[0] = '0;
   assign rem[0] = '0;
   assign den[0] = den_ff;
   assign pay[0] = {pay_ff, prod1};

   for (genvar i = 0; i < NB; i++) begin : g_cell
      q24_div_cell #(.NB(NB), .DB(DB), .PB(CW)) u_cell (
         .clock(clock), .enable(advance),
         .num_i(num[i]), .quo_i(quo[i]), .rem_i(rem[i]), .den_i(den[i]), .pay_i(pay[i]),
         .num_o(num[i+1]), .quo_o(quo[i+1]), .rem_o(rem[i+1]), .den_o(den[i+1]),
         .pay_o(pay[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rsp_valid <= 1'b0;
      end else if (advance) begin
         vld_ff    <= {vld_ff[NB-1:0], req_valid};
         rsp_valid <= vld_ff[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result          <= res_c;
         rsp_a_less          <= flg_c.a_less;
         rsp_a_equal         <= flg_c.a_equal;
         rsp_a_greater       <= flg_c.a_greater;
         rsp_overflowed      <= flg_c.overflowed;
         rsp_divided_by_zero <= flg_c.divided_by_zero;
      end
   end

`ifndef SYNTHESIS
   a_cmp_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
      else $error("compare flags not one-hot");
   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divided_by_zero |-> !rsp_overflowed)
      else $error("divide by zero raised overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("stalled result changed");
`endif

endmodule
